// File: hdl/sbb_pkg.sv
// ----------------------------------------------------------------------------
// sbb_pkg: shared definitions of the separable binomial blur
// Default sizes, fixed field widths, register indexes and handshake types.
// ----------------------------------------------------------------------------
package sbb_pkg;

  localparam int DEF_MAX_WIDTH   = 4096;
  localparam int DEF_SAMPLE_BITS = 16;

  // Fixed widths of the pixel, row and register fields.
  localparam int PIX_BITS    = 16;
  localparam int ROW_BITS    = 16;
  localparam int RWIDTH_BITS = 13;
  localparam int CFG_BITS    = 16;

  typedef enum logic [1:0] {
    CFG_LAYOUT = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_index_t;

  // Sequencer states, one-hot.
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_CALC = 3'b100
  } seq_state_t;

  // Which of the two result slots are pushed into the output queue this cycle.
  typedef struct packed {
    logic first;
    logic second;
  } sbb_push_t;

endpackage

// File: hdl/sbb_line_ram.sv
// ----------------------------------------------------------------------------
// sbb_line_ram: line store of horizontal results
// One write port and one registered read port; each entry holds the results
// of the two previous rows for one column.
// ----------------------------------------------------------------------------
module sbb_line_ram #(
  parameter int DEPTH = 4096,
  parameter int DW    = 32,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/sbb_out_fifo.sv
// ----------------------------------------------------------------------------
// sbb_out_fifo: four-entry result queue
// Takes up to two result words per cycle and hands out one per cycle while ready is high.
// ----------------------------------------------------------------------------
module sbb_out_fifo #(
  parameter int DW = 48
) (
  input  logic              clk,
  input  logic              rst,
  input  sbb_pkg::sbb_push_t push,
  input  logic [DW-1:0]     data_a,
  input  logic [DW-1:0]     data_b,
  output logic              room,
  output logic              valid,
  input  logic              ready,
  output logic [DW-1:0]     data
);
  import sbb_pkg::*;

  logic [DW-1:0] entry [4];
  logic [1:0]    wptr;
  logic [1:0]    rptr;
  logic [2:0]    count;
  logic          pop;
  logic [2:0]    n_push;

  assign pop    = valid && ready;
  assign valid  = (count != 3'd0);
  assign room   = (count <= 3'd2);
  assign data   = entry[rptr];
  assign n_push = {2'b00, push.first} + {2'b00, push.second};

  always_ff @(posedge clk) begin
    if (push.first) begin
      entry[wptr] <= data_a;
    end
    if (push.second) begin
      entry[wptr + {1'b0, push.first}] <= data_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + n_push[1:0];
      rptr  <= rptr + {1'b0, pop};
      count <= count + n_push - {2'b00, pop};
    end
  end

endmodule

// File: hdl/separable_binomial_blur_3x3_core.sv
// ----------------------------------------------------------------------------
// separable_binomial_blur_3x3_core: streaming 3x3 binomial blur
// Horizontal [1,2,1]/4 pass on a sample window, vertical pass on a line store.
// ----------------------------------------------------------------------------
// Each ready column passes the read state (line store read, horizontal result
// registered), then the update state, which waits for room in the output queue.
// Words with no ready column skip both; a job's last update can take a new word.
// At the end of a packed YUY2 row up to four columns finish on one word.
// Reset: synchronous; registers take their defaults, position goes to the origin,
// the queue empties. The line store keeps its contents and needs no clearing.
module separable_binomial_blur_3x3_core #(
  parameter int MAX_WIDTH   = sbb_pkg::DEF_MAX_WIDTH,
  parameter int SAMPLE_BITS = sbb_pkg::DEF_SAMPLE_BITS,
  localparam int COL_BITS   = $clog2(MAX_WIDTH),
  localparam int TDATA_BITS =
    ((sbb_pkg::PIX_BITS + COL_BITS + sbb_pkg::ROW_BITS + 7) / 8) * 8
) (
  input  logic                        clk,
  input  logic                        rst,
  // Configuration write port.
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [sbb_pkg::CFG_BITS-1:0] cfg_data,
  // Input stream. s_tdata: sample.
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [15:0]                 s_tdata,
  // Output stream. m_tdata: pixel, out_column, out_row, zero pad.
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [TDATA_BITS-1:0]       m_tdata,
  output logic                        m_tlast
);
  import sbb_pkg::*;

  localparam int WB   = COL_BITS + 1;
  localparam int CMPW = (WB > RWIDTH_BITS) ? WB : RWIDTH_BITS;
  localparam int SB   = SAMPLE_BITS;
  localparam int AB   = SB + 2;
  localparam int PADW = TDATA_BITS - PIX_BITS - COL_BITS - ROW_BITS;
  localparam int FW   = TDATA_BITS + 1;

  // Configuration registers.
  logic                   layout_mode;
  logic [RWIDTH_BITS-1:0] row_width;
  logic [ROW_BITS-1:0]    frame_height;

  logic [WB-1:0]       w_eff;
  logic [ROW_BITS-1:0] h_eff;
  logic [CMPW-1:0]     wr_ext;

  always_comb begin
    wr_ext = CMPW'(row_width);
    if (wr_ext == '0) begin
      w_eff = WB'(1);
    end else if (wr_ext > CMPW'(MAX_WIDTH)) begin
      w_eff = WB'(MAX_WIDTH);
    end else begin
      w_eff = WB'(wr_ext);
    end
    h_eff = (frame_height == '0) ? ROW_BITS'(1) : frame_height;
  end

  // Raster position of the next word.
  logic [COL_BITS-1:0] col_cnt;
  logic [ROW_BITS-1:0] row_cnt;
  logic [COL_BITS-1:0] c_cl;
  logic [ROW_BITS-1:0] r_cl;
  logic [WB-1:0]       c_inc;
  logic [ROW_BITS:0]   r_inc;

  assign c_cl  = ({1'b0, col_cnt} >= w_eff) ? '0 : col_cnt;
  assign r_cl  = (row_cnt >= h_eff) ? '0 : row_cnt;
  assign c_inc = {1'b0, c_cl} + WB'(1);
  assign r_inc = {1'b0, r_cl} + (ROW_BITS + 1)'(1);

  // Last eight samples; slot 0 is the newest.
  logic [SB-1:0] win [8];
  logic [SB-1:0] cur;
  assign cur = s_tdata[SB-1:0];

  // Current job: captured window (slot 0 is the word itself), its position,
  // and a mask of the columns that this word completes, by offset back from c.
  logic [SB-1:0]       jwin [9];
  logic [COL_BITS-1:0] job_c;
  logic [ROW_BITS-1:0] job_r;
  logic [4:0]          job_mask;

  seq_state_t state;
  seq_state_t state_next;

  // Horizontal distance of a column.
  function automatic logic [2:0] dist_of(input logic mode, input logic odd);
    if (!mode) begin
      return 3'd1;
    end
    return odd ? 3'd4 : 3'd2;
  endfunction

  // A column is ready when its furthest needed sample is the current word.
  logic [4:0] new_mask;

  always_comb begin
    logic [WB-1:0] xo;
    logic [WB:0]   reach;
    for (int o = 0; o < 5; o++) begin
      xo    = {1'b0, c_cl} - WB'(o);
      reach = {1'b0, xo} + (WB + 1)'(dist_of(layout_mode, xo[0]));
      if (reach > {1'b0, w_eff - WB'(1)}) begin
        reach = {1'b0, w_eff - WB'(1)};
      end
      new_mask[o] = ({1'b0, c_cl} >= WB'(o)) && (reach == (WB + 1)'(c_cl));
    end
  end

  // Pick the oldest pending column: the highest offset set.
  logic [2:0] o_sel;
  always_comb begin
    o_sel = 3'd0;
    for (int o = 0; o < 5; o++) begin
      if (job_mask[o]) begin
        o_sel = 3'(o);
      end
    end
  end

  function automatic logic [SB-1:0] pick(input logic [SB-1:0] w [9], input logic [3:0] i);
    return (i <= 4'd8) ? w[i] : '0;
  endfunction

  // Horizontal pass of the selected column.
  logic [COL_BITS-1:0] x_sel;
  logic [2:0]          d_sel;
  logic                has_l;
  logic                has_r;
  logic [SB-1:0]       hv;

  always_comb begin
    logic [AB-1:0] sl;
    logic [AB-1:0] sm;
    logic [AB-1:0] sr;
    logic [AB-1:0] acc;
    x_sel = job_c - COL_BITS'(o_sel);
    d_sel = dist_of(layout_mode, x_sel[0]);
    has_l = ({1'b0, x_sel} >= WB'(d_sel));
    has_r = (({1'b0, x_sel} + WB'(d_sel)) < w_eff);
    sm    = AB'(jwin[o_sel]);
    sl    = AB'(pick(jwin, {1'b0, o_sel} + {1'b0, d_sel}));
    sr    = (o_sel >= d_sel) ? AB'(pick(jwin, {1'b0, o_sel - d_sel})) : '0;
    if (has_l && has_r) begin
      acc = (sl + (sm << 1) + sr + AB'(2)) >> 2;
    end else if (has_l) begin
      acc = (sl + sm + AB'(1)) >> 1;
    end else if (has_r) begin
      acc = (sm + sr + AB'(1)) >> 1;
    end else begin
      acc = sm;
    end
    hv = acc[SB-1:0];
  end

  // Read stage results held for the update stage.
  logic [SB-1:0]       hv_q;
  logic [COL_BITS-1:0] x_q;
  logic                last_q;

  // Line store: {older, newer} per column.
  logic [2*SB-1:0] ram_rdata;
  logic            ram_re;
  logic            ram_we;
  logic [SB-1:0]   od;
  logic [SB-1:0]   nw;

  assign ram_re = (state == ST_READ);
  assign od     = ram_rdata[2*SB-1:SB];
  assign nw     = ram_rdata[SB-1:0];

  sbb_line_ram #(
    .DEPTH (MAX_WIDTH),
    .DW    (2 * SB)
  ) u_line (
    .clk   (clk),
    .we    (ram_we),
    .waddr (x_q),
    .wdata ({nw, hv_q}),
    .re    (ram_re),
    .raddr (x_sel),
    .rdata (ram_rdata)
  );

  // Vertical pass and result words.
  logic            fifo_room;
  sbb_push_t       push;
  logic [FW-1:0]   res_a;
  logic [FW-1:0]   res_b;
  logic            calc_go;

  always_comb begin
    logic [AB-1:0]       v3;
    logic [AB-1:0]       v2;
    logic [SB-1:0]       pa;
    logic [ROW_BITS-1:0] ra;
    v3 = (AB'(od) + (AB'(nw) << 1) + AB'(hv_q) + AB'(2)) >> 2;
    v2 = (AB'(nw) + AB'(hv_q) + AB'(1)) >> 1;
    push = '0;
    pa   = hv_q;
    ra   = '0;
    if (h_eff == ROW_BITS'(1)) begin
      push.first = 1'b1;
    end else if (job_r != '0) begin
      push.first  = 1'b1;
      push.second = (job_r == h_eff - ROW_BITS'(1));
      pa = (job_r == ROW_BITS'(1)) ? v2[SB-1:0] : v3[SB-1:0];
      ra = job_r - ROW_BITS'(1);
    end
    res_a = {last_q && !push.second, PADW'(0), ra, x_q, PIX_BITS'(pa)};
    res_b = {last_q, PADW'(0), job_r, x_q, PIX_BITS'(v2[SB-1:0])};
    if (!(state == ST_CALC && fifo_room)) begin
      push = '0;
    end
  end

  assign calc_go  = (state == ST_CALC) && fifo_room;
  assign ram_we   = calc_go;
  assign s_tready = (state == ST_IDLE) || (calc_go && job_mask == '0);

  logic s_acc;
  assign s_acc = s_tvalid && s_tready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_acc && new_mask != '0) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_CALC;
      end
      ST_CALC: begin
        if (fifo_room) begin
          if (job_mask != '0) begin
            state_next = ST_READ;
          end else if (s_acc && new_mask != '0) begin
            state_next = ST_READ;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration and position.
  always_ff @(posedge clk) begin
    if (rst) begin
      layout_mode  <= 1'b0;
      row_width    <= RWIDTH_BITS'(1920);
      frame_height <= ROW_BITS'(1080);
      col_cnt      <= '0;
      row_cnt      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LAYOUT: begin
          layout_mode <= cfg_data[0];
          col_cnt     <= '0;
          row_cnt     <= '0;
        end
        CFG_WIDTH: begin
          row_width <= cfg_data[RWIDTH_BITS-1:0];
          col_cnt   <= '0;
          row_cnt   <= '0;
        end
        CFG_HEIGHT: begin
          frame_height <= cfg_data;
          col_cnt      <= '0;
          row_cnt      <= '0;
        end
        default: begin
        end
      endcase
    end else if (s_acc) begin
      if (c_inc >= w_eff) begin
        col_cnt <= '0;
        row_cnt <= (r_inc >= {1'b0, h_eff}) ? '0 : r_inc[ROW_BITS-1:0];
      end else begin
        col_cnt <= c_inc[COL_BITS-1:0];
        row_cnt <= r_cl;
      end
    end
  end

  // Sample window.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) begin
        win[i] <= '0;
      end
    end else if (s_acc) begin
      win[0] <= cur;
      for (int i = 1; i < 8; i++) begin
        win[i] <= win[i-1];
      end
    end
  end

  // Job capture and column selection.
  always_ff @(posedge clk) begin
    if (rst) begin
      job_mask <= '0;
    end else if (s_acc) begin
      job_mask <= new_mask;
    end else if (state == ST_READ) begin
      job_mask[o_sel] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      jwin[0] <= cur;
      for (int i = 1; i < 9; i++) begin
        jwin[i] <= win[i-1];
      end
      job_c <= c_cl;
      job_r <= r_cl;
    end
    if (state == ST_READ) begin
      hv_q   <= hv;
      x_q    <= x_sel;
      last_q <= ((job_mask & ~(5'b00001 << o_sel)) == '0);
    end
  end

  // Output queue.
  logic [FW-1:0] fifo_data;

  sbb_out_fifo #(
    .DW (FW)
  ) u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .data_a (res_a),
    .data_b (res_b),
    .room   (fifo_room),
    .valid  (m_tvalid),
    .ready  (m_tready),
    .data   (fifo_data)
  );

  assign m_tdata = fifo_data[TDATA_BITS-1:0];
  assign m_tlast = fifo_data[FW-1];

endmodule

// File: hdl/sbb_checker.sv
// ----------------------------------------------------------------------------
// sbb_checker: port-level checks of the blur core
// Watches the stream ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module sbb_checker #(
  parameter int MAX_WIDTH   = sbb_pkg::DEF_MAX_WIDTH,
  parameter int SAMPLE_BITS = sbb_pkg::DEF_SAMPLE_BITS,
  localparam int COL_BITS   = $clog2(MAX_WIDTH),
  localparam int TDATA_BITS =
    ((sbb_pkg::PIX_BITS + COL_BITS + sbb_pkg::ROW_BITS + 7) / 8) * 8
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [TDATA_BITS-1:0] m_tdata,
  input logic                  m_tlast
);
  import sbb_pkg::*;

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output word changed while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  a_reset_ready: assert property (@(posedge clk) rst |=> s_tready)
    else $error("input not ready right after reset");

  a_pixel_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[PIX_BITS-1:0] >> SAMPLE_BITS) == '0))
    else $error("pixel exceeds sample width");

endmodule

bind separable_binomial_blur_3x3_core sbb_checker #(
  .MAX_WIDTH   (MAX_WIDTH),
  .SAMPLE_BITS (SAMPLE_BITS)
) u_sbb_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

// File: sim/tb_separable_binomial_blur_3x3_core.sv
// ----------------------------------------------------------------------------
// tb_separable_binomial_blur_3x3_core: stream test of the 3x3 binomial blur
// Small planes in planar and packed YUY2 layouts are streamed through the core.
// A model in the bench predicts every output word, and the monitor compares it.
// ----------------------------------------------------------------------------
module tb_separable_binomial_blur_3x3_core;
  timeunit 1ns;
  timeprecision 1ps;
  import sbb_pkg::*;

  localparam int MAXW = DEF_MAX_WIDTH;
  localparam int COLB = $clog2(MAXW);
  localparam int TDW  = ((PIX_BITS + COLB + ROW_BITS + 7) / 8) * 8;
  localparam int LIMIT = 400000;

  typedef struct packed {
    logic [15:0] pixel;
    logic [11:0] col;
    logic [15:0] row;
    logic        last;
  } blur_word_t;

  logic clk, rst;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [CFG_BITS-1:0] cfg_data;
  logic s_tvalid, s_tready;
  logic [15:0] s_tdata;
  logic m_tvalid, m_tready;
  logic [TDW-1:0] m_tdata;
  logic m_tlast;

  separable_binomial_blur_3x3_core u_top (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .s_tvalid, .s_tready, .s_tdata,
    .m_tvalid, .m_tready, .m_tdata, .m_tlast
  );

  // Model state, a copy of the core's registers, window and line stores.
  logic        mdl_yuy2;
  logic [12:0] mdl_width;
  logic [15:0] mdl_height;
  logic [15:0] win [8];
  logic [15:0] line_old [MAXW];
  logic [15:0] line_new [MAXW];
  int          col_pos, row_pos;

  logic [15:0] sample_q[$];   // words waiting for the driver
  blur_word_t  blurred_q[$];  // predicted output words, oldest first
  int          errors = 0;
  int          cycles = 0;
  bit          drive_idle_ok, recv_idle_ok, hold_recv;
  int          hold_cnt;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  task automatic report(input string what);
    $display("mismatch at cycle %0d: %s", cycles, what);
    errors++;
  endtask

  function automatic int eff_w();
    if (mdl_width == 0) return 1;
    if (mdl_width > MAXW) return MAXW;
    return mdl_width;
  endfunction

  function automatic int eff_h();
    return (mdl_height == 0) ? 1 : mdl_height;
  endfunction

  function automatic int hdist(int x);
    if (!mdl_yuy2) return 1;
    return x[0] ? 4 : 2;
  endfunction

  function automatic int tap(int j, int c, int cur);
    int k;
    if (j == c) return cur;
    if (j > c) return 0;
    k = c - 1 - j;
    return (k < 8) ? win[k] : 0;
  endfunction

  function automatic int hsmooth(int x, int c, int cur, int w);
    int d, m;
    bit hl, hr;
    d = hdist(x);
    hl = x >= d;
    hr = x + d < w;
    m = tap(x, c, cur);
    if (hl && hr) return (tap(x - d, c, cur) + (m << 1) + tap(x + d, c, cur) + 2) >> 2;
    if (hl) return (tap(x - d, c, cur) + m + 1) >> 1;
    if (hr) return (m + tap(x + d, c, cur) + 1) >> 1;
    return m;
  endfunction

  // Predicts the output words that one accepted sample causes.
  task automatic predict_blur(input logic [15:0] smp);
    int w, h, c, r, cur, x, reach, hv, nw, od, v, n0;
    blur_word_t bw;
    w = eff_w(); h = eff_h(); c = col_pos; r = row_pos; cur = smp;
    n0 = blurred_q.size();
    if (c >= w) c = 0;
    if (r >= h) r = 0;
    for (x = (c >= 4 ? c - 4 : 0); x <= c; x++) begin
      reach = x + hdist(x);
      if (reach > w - 1) reach = w - 1;
      if (reach != c || x >= MAXW) continue;
      hv = hsmooth(x, c, cur, w);
      nw = line_new[x];
      od = line_old[x];
      bw.last = 0;
      bw.col = 12'(x);
      if (h == 1) begin
        bw.pixel = 16'(hv); bw.row = 16'(0);
        blurred_q.push_back(bw);
      end else if (r >= 1) begin
        v = (r == 1) ? (nw + hv + 1) >> 1 : (od + (nw << 1) + hv + 2) >> 2;
        bw.pixel = 16'(v); bw.row = 16'(r - 1);
        blurred_q.push_back(bw);
        if (r == h - 1) begin
          bw.pixel = 16'((nw + hv + 1) >> 1); bw.row = 16'(r);
          blurred_q.push_back(bw);
        end
      end
      line_old[x] = 16'(nw);
      line_new[x] = 16'(hv);
    end
    for (int i = 7; i > 0; i--) win[i] = win[i-1];
    win[0] = smp;
    c++;
    if (c >= w) begin
      c = 0; r++;
      if (r >= h) r = 0;
    end
    col_pos = c; row_pos = r;
    if (blurred_q.size() > n0) blurred_q[$].last = 1;
  endtask

  // Writes a register through the configuration port; the model follows the same rules.
  task automatic write_reg(input cfg_index_t idx, input int val);
    @(posedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= CFG_BITS'(val);
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      CFG_LAYOUT: mdl_yuy2 = val[0];
      CFG_WIDTH:  mdl_width = val[12:0];
      CFG_HEIGHT: mdl_height = val[15:0];
      default: ;
    endcase
    col_pos = 0; row_pos = 0;
  endtask

  // Waits until the driver has sent everything and all results are back.
  task automatic drain();
    while (sample_q.size() != 0 || s_tvalid || blurred_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // Queues one whole plane. Mostly random content; a few planes use extreme values.
  task automatic queue_plane(input int w, input int h, input int kind);
    for (int i = 0; i < w * h; i++) begin
      case (kind)
        0: sample_q.push_back(16'($urandom_range(0, 65535)));
        1: sample_q.push_back(16'hFFFF);
        2: sample_q.push_back(16'h0000);
        default: sample_q.push_back(i[0] ? 16'hFFFF : 16'h0000);
      endcase
    end
  endtask

  task automatic run_plane(input bit yuy2, input int w, input int h, input int kind);
    write_reg(CFG_LAYOUT, yuy2);
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    queue_plane(w, h, kind);
    drain();
  endtask

  // Driver: offers queued samples, with random idle bursts early in the run.
  int drv_gap;
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 0;
      drv_gap <= 0;
    end else begin
      if (s_tvalid && s_tready) predict_blur(s_tdata);
      if (!s_tvalid || s_tready) begin
        if (drv_gap > 0) begin
          drv_gap <= drv_gap - 1;
          s_tvalid <= 0;
        end else if (sample_q.size() != 0) begin
          if (drive_idle_ok && $urandom_range(0, 7) == 0) begin
            drv_gap <= $urandom_range(1, 16) - 1;
            s_tvalid <= 0;
          end else begin
            s_tdata <= sample_q.pop_front();
            s_tvalid <= 1;
          end
        end else begin
          s_tvalid <= 0;
        end
      end
    end
  end

  // Receiver: random stall bursts, plus a long hold-off when requested.
  int rcv_gap;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 0;
      rcv_gap <= 0;
      hold_cnt <= 0;
    end else if (hold_recv && hold_cnt < 300) begin
      hold_cnt <= hold_cnt + 1;
      m_tready <= 0;
    end else if (rcv_gap > 0) begin
      rcv_gap <= rcv_gap - 1;
      m_tready <= 0;
    end else if (recv_idle_ok && $urandom_range(0, 7) == 0) begin
      rcv_gap <= $urandom_range(1, 16) - 1;
      m_tready <= 0;
    end else begin
      m_tready <= 1;
    end
  end

  // Monitor: compares each accepted output word with the oldest prediction.
  always @(posedge clk) begin
    blur_word_t exp_w;
    if (!rst && m_tvalid && m_tready) begin
      if (blurred_q.size() == 0) begin
        report($sformatf("unexpected word %h", m_tdata));
      end else begin
        exp_w = blurred_q.pop_front();
        if (m_tdata[15:0] != exp_w.pixel)
          report($sformatf("pixel %h, expected %h", m_tdata[15:0], exp_w.pixel));
        if (m_tdata[16 +: COLB] != exp_w.col)
          report($sformatf("column %0d, expected %0d", m_tdata[16 +: COLB], exp_w.col));
        if (m_tdata[16 + COLB +: 16] != exp_w.row)
          report($sformatf("row %0d, expected %0d", m_tdata[16 + COLB +: 16], exp_w.row));
        if (m_tlast != exp_w.last)
          report($sformatf("tlast %b, expected %b", m_tlast, exp_w.last));
      end
    end
  end

  // Cycle limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("separable_binomial_blur_3x3_core test failed");
      $finish;
    end
  end

  initial begin
    int w, h;
    bit y;
    rst = 1; cfg_we = 0; cfg_index = CFG_LAYOUT; cfg_data = 0;
    drive_idle_ok = 1; recv_idle_ok = 1; hold_recv = 0;
    mdl_yuy2 = 0; mdl_width = 1920; mdl_height = 1080;
    col_pos = 0; row_pos = 0;
    foreach (win[i]) win[i] = 0;
    repeat (12) @(posedge clk);
    rst <= 0;
    repeat (2) @(posedge clk);

    // Directed planes: single pixel, single row, single column, extreme values.
    run_plane(0, 1, 1, 1);
    run_plane(0, 5, 1, 3);
    run_plane(0, 1, 4, 2);
    run_plane(0, 3, 3, 1);
    run_plane(1, 4, 2, 3);
    run_plane(1, 4, 1, 1);
    // Odd width in packed mode uses the same edge rules.
    run_plane(1, 5, 2, 0);

    // Long receiver hold-off while the sender keeps offering samples.
    write_reg(CFG_LAYOUT, 0);
    write_reg(CFG_WIDTH, 6);
    write_reg(CFG_HEIGHT, 6);
    hold_recv = 1;
    queue_plane(6, 6, 0);
    drain();
    hold_recv = 0;

    // Random planes; the last ones without idling.
    for (int p = 0; p < 12; p++) begin
      if (p >= 9) begin
        drive_idle_ok = 0;
        recv_idle_ok = 0;
      end
      y = $urandom_range(0, 1);
      w = y ? 4 * $urandom_range(1, 3) : $urandom_range(1, 10);
      h = $urandom_range(1, 5);
      run_plane(y, w, h, 0);
    end

    // A longer single row, after the largest height has been written idle.
    write_reg(CFG_HEIGHT, 65535);
    run_plane(0, 64, 1, 0);
    repeat (20) @(posedge clk);
    if (errors == 0 && blurred_q.size() == 0) begin
      $display("separable_binomial_blur_3x3_core test passed");
    end else begin
      $display("separable_binomial_blur_3x3_core test failed");
    end
    $finish;
  end
endmodule
